@@ rtl/ebe_ssor_pkg.sv @@
// shared types, codes and constants of the triangle sweep block
package ebe_ssor_pkg;

    localparam int DEF_MAX_EQUATIONS = 65536;
    localparam int DEF_FRACTION_BITS = 16;
    localparam int OMEGA_FRAC        = 16;

    localparam int IDX_W      = 16;
    localparam int VAL_W      = 32;
    localparam int CMD_W      = 2;
    localparam int ST_W       = 2;
    localparam int OMEGA_W    = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ELEM  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_SAT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OMEGA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMEQ = 2'd2;

    localparam logic [OMEGA_W-1:0] OMEGA_RESET = 18'd65536;
    localparam logic [IDX_W-1:0]   NUMEQ_RESET = 16'd65535;

    localparam logic [1:0] ADDR_INDEX = 2'd0;
    localparam logic [1:0] ADDR_NODE0 = 2'd1;
    localparam logic [1:0] ADDR_NODE1 = 2'd2;
    localparam logic [1:0] ADDR_NODE2 = 2'd3;

    localparam logic [1:0] WR_ENTRY  = 2'd0;
    localparam logic [1:0] WR_FIRST  = 2'd1;
    localparam logic [1:0] WR_SECOND = 2'd2;

    localparam logic [2:0] MUL_NONE = 3'd0;
    localparam logic [2:0] MUL_K1   = 3'd1;
    localparam logic [2:0] MUL_K2   = 3'd2;
    localparam logic [2:0] MUL_K3   = 3'd3;
    localparam logic [2:0] MUL_T1   = 3'd4;
    localparam logic [2:0] MUL_TA   = 3'd5;
    localparam logic [2:0] MUL_TB   = 3'd6;

    localparam logic [1:0] NODE0 = 2'd0;
    localparam logic [1:0] NODE1 = 2'd1;
    localparam logic [1:0] NODE2 = 2'd2;

    localparam logic [1:0] COEF_SINGLE = 2'd0;
    localparam logic [1:0] COEF_FIRST  = 2'd1;
    localparam logic [1:0] COEF_SECOND = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        node0;
        logic [IDX_W-1:0]        node1;
        logic [IDX_W-1:0]        node2;
        logic signed [VAL_W-1:0] coef_single;
        logic signed [VAL_W-1:0] coef_pair_first;
        logic signed [VAL_W-1:0] coef_pair_second;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [ST_W-1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic       load_item;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic [2:0] mul_sel;
        logic       k_cap;
        logic [1:0] k_sel;
        logic       z_cap;
        logic [1:0] z_sel;
        logic       mid_cap;
        logic       acc_cap;
        logic       dst_cap;
        logic       rdval_cap;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             bad;
    } t_dp_stat;

endpackage

@@ rtl/ebe_ssor_ram.sv @@
// generic single-clock ram with one write port and one registered read port
module ebe_ssor_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ebe_ssor_dp.sv @@
// datapath: config registers, solution ram, shared multiplier and saturation
module ebe_ssor_dp #(
    parameter int MAX_EQUATIONS = ebe_ssor_pkg::DEF_MAX_EQUATIONS,
    parameter int FRACTION_BITS = ebe_ssor_pkg::DEF_FRACTION_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [ebe_ssor_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ebe_ssor_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  ebe_ssor_pkg::t_in_item                 i_in_item,
    input  ebe_ssor_pkg::t_dp_cmd                  i_cmd,
    output ebe_ssor_pkg::t_dp_stat                 o_stat,
    output ebe_ssor_pkg::t_out_item                o_out_item
);
    import ebe_ssor_pkg::*;

    localparam int AW = $clog2(MAX_EQUATIONS);
    localparam logic [31:0] MAX_EQ_W = 32'(MAX_EQUATIONS);
    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > SAT_HI) begin
            return 32'sh7fff_ffff;
        end else if (v < SAT_LO) begin
            return 32'sh8000_0000;
        end
        return 32'(v);
    endfunction

    function automatic logic ovf32(input logic signed [63:0] v);
        return (v > SAT_HI) || (v < SAT_LO);
    endfunction

    logic [OMEGA_W-1:0] r_omega;
    logic               r_backward;
    logic [IDX_W-1:0]   r_num_eq;

    t_in_item           r_item;
    logic signed [31:0] r_k [3];
    logic signed [31:0] r_z [3];
    logic signed [31:0] r_mid;
    logic signed [31:0] r_dst;
    logic signed [63:0] r_acc;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_rdval;
    logic               r_sat;
    t_out_item          r_out;

    logic [IDX_W-1:0] probe   [4];
    logic [AW-1:0]    addr_of [4];
    logic [3:0]       regular;
    logic [3:0]       fixed;
    logic [3:0]       bad;
    logic             item_bad;

    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;
    logic               wr_ok;
    logic [31:0]        rdata;
    logic signed [31:0] rd_z;
    logic signed [31:0] src;
    logic signed [31:0] dst_old;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] k_wide;
    logic signed [63:0] term;
    logic signed [63:0] mid_wide;
    logic signed [63:0] acc_wide;
    logic signed [63:0] fin_wide;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_omega    <= OMEGA_RESET;
            r_backward <= 1'b0;
            r_num_eq   <= NUMEQ_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OMEGA: r_omega    <= i_cfg_data;
                CFG_SWEEP: r_backward <= i_cfg_data[0];
                CFG_NUMEQ: r_num_eq   <= i_cfg_data[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // slot classification of index and the three nodes
    always_comb begin
        probe[0] = r_item.index;
        probe[1] = r_item.node0;
        probe[2] = r_item.node1;
        probe[3] = r_item.node2;
        for (int i = 0; i < 4; i++) begin
            fixed[i]   = (probe[i] == r_num_eq);
            regular[i] = (probe[i] < r_num_eq) && (32'(probe[i]) < MAX_EQ_W);
            bad[i]     = !fixed[i] && !regular[i];
            addr_of[i] = AW'(probe[i]);
        end
    end

    always_comb begin
        case (r_item.cmd)
            CMD_WRITE: item_bad = bad[0];
            CMD_READ:  item_bad = bad[0];
            CMD_ELEM:  item_bad = bad[1] | bad[2] | bad[3];
            default:   item_bad = 1'b0;
        endcase
    end

    assign o_stat.cmd = r_item.cmd;
    assign o_stat.bad = item_bad;

    // memory ports
    always_comb begin
        case (i_cmd.rd_sel)
            ADDR_INDEX: rd_addr = addr_of[0];
            ADDR_NODE0: rd_addr = addr_of[1];
            ADDR_NODE1: rd_addr = addr_of[2];
            ADDR_NODE2: rd_addr = addr_of[3];
            default:    rd_addr = addr_of[0];
        endcase
    end

    always_comb begin
        wr_addr = addr_of[0];
        wr_data = r_item.value;
        wr_ok   = 1'b0;
        case (i_cmd.wr_sel)
            WR_ENTRY: begin
                wr_addr = addr_of[0];
                wr_data = r_item.value;
                wr_ok   = regular[0];
            end
            WR_FIRST: begin
                if (r_backward) begin
                    wr_addr = addr_of[1];
                    wr_data = r_dst;
                    wr_ok   = regular[1];
                end else begin
                    wr_addr = addr_of[2];
                    wr_data = r_mid;
                    wr_ok   = regular[2];
                end
            end
            WR_SECOND: begin
                if (r_backward) begin
                    wr_addr = addr_of[2];
                    wr_data = r_mid;
                    wr_ok   = regular[2];
                end else begin
                    wr_addr = addr_of[3];
                    wr_data = r_dst;
                    wr_ok   = regular[3];
                end
            end
            default: ;
        endcase
    end

    ebe_ssor_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_EQUATIONS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en & wr_ok),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    // shared multiplier
    assign src     = r_backward ? r_z[2] : r_z[0];
    assign dst_old = r_backward ? r_z[0] : r_z[2];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_sel)
            MUL_K1: begin
                mul_a = 32'(r_omega);
                mul_b = r_item.coef_single;
            end
            MUL_K2: begin
                mul_a = 32'(r_omega);
                mul_b = r_item.coef_pair_first;
            end
            MUL_K3: begin
                mul_a = 32'(r_omega);
                mul_b = r_item.coef_pair_second;
            end
            MUL_T1: begin
                mul_a = r_k[0];
                mul_b = src;
            end
            MUL_TA: begin
                mul_a = r_backward ? r_k[2] : r_k[1];
                mul_b = src;
            end
            MUL_TB: begin
                mul_a = r_backward ? r_k[1] : r_k[2];
                mul_b = r_mid;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
    end

    assign k_wide   = r_prod >>> OMEGA_FRAC;
    assign term     = r_prod >>> FRACTION_BITS;
    assign mid_wide = 64'(r_z[1]) - term;
    assign acc_wide = 64'(dst_old) - term;
    assign fin_wide = r_acc - term;

    // fixed slot reads as zero
    always_comb begin
        case (i_cmd.z_sel)
            NODE0:   rd_z = regular[1] ? $signed(rdata) : '0;
            NODE1:   rd_z = regular[2] ? $signed(rdata) : '0;
            NODE2:   rd_z = regular[3] ? $signed(rdata) : '0;
            default: rd_z = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item  <= i_in_item;
            r_rdval <= '0;
            r_sat   <= 1'b0;
        end
        if (i_cmd.z_cap) begin
            case (i_cmd.z_sel)
                NODE0:   r_z[0] <= rd_z;
                NODE1:   r_z[1] <= rd_z;
                NODE2:   r_z[2] <= rd_z;
                default: ;
            endcase
        end
        if (i_cmd.k_cap) begin
            case (i_cmd.k_sel)
                COEF_SINGLE: r_k[0] <= sat32(k_wide);
                COEF_FIRST:  r_k[1] <= sat32(k_wide);
                COEF_SECOND: r_k[2] <= sat32(k_wide);
                default: ;
            endcase
            if (ovf32(k_wide)) begin
                r_sat <= 1'b1;
            end
        end
        if (i_cmd.mid_cap) begin
            r_mid <= sat32(mid_wide);
            if (ovf32(mid_wide)) begin
                r_sat <= 1'b1;
            end
        end
        if (i_cmd.acc_cap) begin
            r_acc <= acc_wide;
        end
        if (i_cmd.dst_cap) begin
            r_dst <= sat32(fin_wide);
            if (ovf32(fin_wide)) begin
                r_sat <= 1'b1;
            end
        end
        if (i_cmd.rdval_cap) begin
            r_rdval <= regular[0] ? $signed(rdata) : '0;
        end
        if (i_cmd.out_load) begin
            r_out.read_value <= r_rdval;
            r_out.status     <= item_bad ? ST_RANGE : (r_sat ? ST_SAT : ST_OK);
        end
    end

    assign o_out_item = r_out;

    property p_status_only_from_flags;
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && !item_bad && !r_sat) |=> (r_out.status == ST_OK);
    endproperty
    a_status_only_from_flags: assert property (p_status_only_from_flags)
        else $error("ok item reported a non-ok status");

endmodule

@@ rtl/ebe_ssor_ctrl.sv @@
// controller: sequences reads, multiplies and writes for one item at a time
module ebe_ssor_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    input  ebe_ssor_pkg::t_dp_stat i_stat,
    output ebe_ssor_pkg::t_dp_cmd  o_cmd
);
    import ebe_ssor_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_WR     = 4'd2;
    localparam logic [3:0] S_RX0    = 4'd3;
    localparam logic [3:0] S_RX1    = 4'd4;
    localparam logic [3:0] S_E0     = 4'd5;
    localparam logic [3:0] S_E1     = 4'd6;
    localparam logic [3:0] S_E2     = 4'd7;
    localparam logic [3:0] S_E3     = 4'd8;
    localparam logic [3:0] S_E4     = 4'd9;
    localparam logic [3:0] S_E5     = 4'd10;
    localparam logic [3:0] S_E6     = 4'd11;
    localparam logic [3:0] S_E7     = 4'd12;
    localparam logic [3:0] S_E8     = 4'd13;
    localparam logic [3:0] S_E9     = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.bad) begin
                    n_state = S_DONE;
                end else begin
                    case (i_stat.cmd)
                        CMD_WRITE: n_state = S_WR;
                        CMD_READ:  n_state = S_RX0;
                        CMD_ELEM:  n_state = S_E0;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_ENTRY;
                n_state = S_DONE;
            end
            S_RX0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = ADDR_INDEX;
                n_state = S_RX1;
            end
            S_RX1: begin
                o_cmd.rdval_cap = 1'b1;
                n_state = S_DONE;
            end
            S_E0: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = ADDR_NODE0;
                o_cmd.mul_sel = MUL_K1;
                n_state = S_E1;
            end
            S_E1: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = ADDR_NODE1;
                o_cmd.z_cap   = 1'b1;
                o_cmd.z_sel   = NODE0;
                o_cmd.k_cap   = 1'b1;
                o_cmd.k_sel   = COEF_SINGLE;
                o_cmd.mul_sel = MUL_K2;
                n_state = S_E2;
            end
            S_E2: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = ADDR_NODE2;
                o_cmd.z_cap   = 1'b1;
                o_cmd.z_sel   = NODE1;
                o_cmd.k_cap   = 1'b1;
                o_cmd.k_sel   = COEF_FIRST;
                o_cmd.mul_sel = MUL_K3;
                n_state = S_E3;
            end
            S_E3: begin
                o_cmd.z_cap = 1'b1;
                o_cmd.z_sel = NODE2;
                o_cmd.k_cap = 1'b1;
                o_cmd.k_sel = COEF_SECOND;
                n_state = S_E4;
            end
            S_E4: begin
                o_cmd.mul_sel = MUL_T1;
                n_state = S_E5;
            end
            S_E5: begin
                o_cmd.mid_cap = 1'b1;
                o_cmd.mul_sel = MUL_TA;
                n_state = S_E6;
            end
            S_E6: begin
                o_cmd.acc_cap = 1'b1;
                o_cmd.mul_sel = MUL_TB;
                n_state = S_E7;
            end
            S_E7: begin
                o_cmd.dst_cap = 1'b1;
                n_state = S_E8;
            end
            S_E8: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_FIRST;
                n_state = S_E9;
            end
            S_E9: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_SECOND;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && r_state == S_DECODE))
        else $error("accepted item did not start decode");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == S_IDLE && r_out_valid))
        else $error("result not presented after load");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> out_free)
        else $error("pending result overwritten");

    a_write_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_E9) |-> ($past(r_state) == S_E8))
        else $error("element second write without first");

    a_no_mem_access_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!o_cmd.wr_en && !o_cmd.rd_en))
        else $error("memory access while idle");

endmodule

@@ rtl/ebe_ssor_triangle_sweep.sv @@
// top level of the element-by-element ssor triangle sweep block
// The block keeps a solution vector of signed Q16.16 entries in one ram with a
// write port and a registered read port, and works on one item at a time. It
// accepts no new item until the current one has loaded its result into the
// output register, which waits while an earlier result is held by i_out_stall;
// an item with an out-of-range index goes straight to its result. For an element
// item the ram's read port serves the three node reads and its write port the
// two writes in turn, and the one shared 32x32 multiplier forms the three
// weighted couplings and the three update terms in sequence with a register
// after each product. Entries must be written before they are read, either
// directly or through an element.
module ebe_ssor_triangle_sweep #(
    parameter int MAX_EQUATIONS = ebe_ssor_pkg::DEF_MAX_EQUATIONS,
    parameter int FRACTION_BITS = ebe_ssor_pkg::DEF_FRACTION_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ebe_ssor_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ebe_ssor_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  ebe_ssor_pkg::t_in_item              i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output ebe_ssor_pkg::t_out_item             o_out_item
);
    import ebe_ssor_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    ebe_ssor_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    ebe_ssor_dp #(
        .MAX_EQUATIONS (MAX_EQUATIONS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_item  (o_out_item)
    );

endmodule
